/* rtl/encoder_period_speed_to_ascii_defines.svh */
// Assertion macros for the encoder period to speed block.
// Included by rtl/encoder_period_speed_to_ascii.sv; no other dependencies.
`ifndef ENCODER_PERIOD_SPEED_TO_ASCII_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_TO_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge out of reset
`define EPSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every clock edge, reset included
`define EPSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define EPSA_ASSERT(lbl, prop, msg)
`define EPSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/epsa_pkg.sv */
// Types and constants of the encoder period to speed block.
// No dependencies; imported by rtl/encoder_period_speed_to_ascii.sv.
package epsa_pkg;

    // Register indexes on the configuration port (word address bit 2)
    localparam logic REG_PERIOD_DIVISOR = 1'b0;
    localparam logic REG_EDGES_PER_REV  = 1'b1;

    // Register reset values
    localparam logic [7:0]  PERIOD_DIVISOR_RST = 8'd5;
    localparam logic [15:0] EDGES_PER_REV_RST  = 16'd528;

    // Speed numerator: 1e9, needs 30 bits
    localparam int          NUM_BITS        = 30;
    localparam logic [29:0] SPEED_NUMERATOR = 30'd1000000000;
    localparam logic [15:0] SPEED_MAX       = 16'hFFFF;

    // Decimal conversion
    localparam int         BCD_STEPS  = 16;
    localparam logic [5:0] ASCII_ZERO = 6'h30;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV_US  = 6'b000010,
        S_MUL     = 6'b000100,
        S_DIV_SPD = 6'b001000,
        S_BCD     = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    // Double-dabble correction of one BCD digit
    function automatic logic [3:0] bcd_adjust(input logic [3:0] nib);
        bcd_adjust = (nib >= 4'd5) ? nib + 4'd3 : nib;
    endfunction

endpackage

/* rtl/encoder_period_speed_to_ascii.sv */
// Encoder period measurement, speed division and ASCII digit split.
// Depends on rtl/epsa_pkg.sv and rtl/encoder_period_speed_to_ascii_defines.svh.

// Each input word is a TIMER_BITS-wide timer capture taken at a rising encoder
// edge. The block returns the wrapped tick period, the speed in hundredths of a
// rev/s as floor(1e9 / (edges_per_rev_x10 * floor(period / period_divisor))),
// its five ASCII digits (the display point follows digit_hundreds) and a flag
// set when the speed is clamped to 65535. Each word goes through a bit-serial
// restoring divider that gives one quotient bit per cycle for both divisions
// (TIMER_BITS steps, then 30 steps), and then a 16-step binary to BCD
// conversion; the speed division is skipped when the product is zero. The
// input side is ready only while the sequencer is idle; the result sits in
// an output register, so the next word is taken while a result still waits.
// The first capture after reset is measured against zero.
`include "encoder_period_speed_to_ascii_defines.svh"

module encoder_period_speed_to_ascii #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] edge_time
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] period_ticks, [31:16] speed_centi,
                                   // [37:32] digit_ten_thousands, [43:38] digit_thousands,
                                   // [49:44] digit_hundreds, [55:50] digit_tens,
                                   // [61:56] digit_units, [63:62] zero
    output logic        m_tuser,   // [0] saturated
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import epsa_pkg::*;

    // Dividend/quotient width, divisor/remainder width, step counter width
    localparam int NW = (TIMER_BITS > NUM_BITS) ? TIMER_BITS : NUM_BITS;
    localparam int DW = 16 + TIMER_BITS;
    localparam int CW = $clog2(NW + 1);

    // Configuration registers
    logic [7:0]  div_cfg_reg;
    logic [15:0] epr_cfg_reg;

    // Sequencer and data path
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     last_reg, last_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   dsr_reg, dsr_next;
    logic [15:0]     per_reg, per_next;
    logic [15:0]     spd_reg, spd_next;
    logic            sat_reg, sat_next;
    logic [15:0]     bin_reg, bin_next;
    logic [19:0]     bcd_reg, bcd_next;

    // Output register
    logic            mvld_reg, mvld_next;
    logic [63:0]     mdat_reg, mdat_next;
    logic            musr_reg, musr_next;

    // Combinational helpers
    logic [TIMER_BITS-1:0] now_tb;
    logic [TIMER_BITS-1:0] period_tb;
    logic [7:0]            div_eff;
    logic [DW:0]           r_shift;
    logic                  q_bit;
    logic [DW-1:0]         rem_step;
    logic [NW-1:0]         quo_step;
    logic [TIMER_BITS-1:0] micros;
    logic [DW-1:0]         product;
    logic [19:0]           bcd_adj;
    logic                  accept;
    logic                  cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cfg_reg <= PERIOD_DIVISOR_RST;
            epr_cfg_reg <= EDGES_PER_REV_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_PERIOD_DIVISOR: div_cfg_reg <= pwdata[7:0];
                REG_EDGES_PER_REV:  epr_cfg_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PERIOD_DIVISOR: prdata = {24'd0, div_cfg_reg};
            REG_EDGES_PER_REV:  prdata = {16'd0, epr_cfg_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Period against the previous capture, wrapped to the timer width
    assign now_tb    = TIMER_BITS'(s_tdata);
    assign period_tb = now_tb - TIMER_BITS'(last_reg);
    assign div_eff   = (div_cfg_reg == 8'd0) ? 8'd1 : div_cfg_reg;

    // Shared restoring divide step: one quotient bit per cycle
    assign r_shift  = {rem_reg, quo_reg[NW-1]};
    assign q_bit    = (r_shift >= {1'b0, dsr_reg});
    assign rem_step = q_bit ? DW'(r_shift - {1'b0, dsr_reg}) : DW'(r_shift);
    assign quo_step = {quo_reg[NW-2:0], q_bit};

    // Edges times microseconds
    assign micros  = quo_reg[TIMER_BITS-1:0];
    assign product = DW'(epr_cfg_reg) * DW'(micros);

    // Double-dabble digit correction
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            bcd_adj[4*i +: 4] = bcd_adjust(bcd_reg[4*i +: 4]);
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        per_next   = per_reg;
        spd_next   = spd_reg;
        sat_next   = sat_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        mvld_next  = mvld_reg & ~m_tready;
        mdat_next  = mdat_reg;
        musr_next  = musr_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next  = 16'(now_tb);
                    per_next   = 16'(period_tb);
                    quo_next   = NW'(period_tb) << (NW - TIMER_BITS);
                    rem_next   = '0;
                    dsr_next   = DW'(div_eff);
                    cnt_next   = CW'(TIMER_BITS);
                    state_next = S_DIV_US;
                end
            end
            S_DIV_US: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                dsr_next = product;
                if (epr_cfg_reg == 16'd0 || micros == '0) begin
                    // zero product: clamp straight away
                    spd_next   = SPEED_MAX;
                    sat_next   = 1'b1;
                    bin_next   = SPEED_MAX;
                    bcd_next   = '0;
                    cnt_next   = CW'(BCD_STEPS);
                    state_next = S_BCD;
                end else begin
                    quo_next   = NW'(SPEED_NUMERATOR) << (NW - NUM_BITS);
                    rem_next   = '0;
                    cnt_next   = CW'(NUM_BITS);
                    state_next = S_DIV_SPD;
                end
            end
            S_DIV_SPD: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if (|quo_step[NUM_BITS-1:16]) begin
                        spd_next = SPEED_MAX;
                        sat_next = 1'b1;
                        bin_next = SPEED_MAX;
                    end else begin
                        spd_next = quo_step[15:0];
                        sat_next = 1'b0;
                        bin_next = quo_step[15:0];
                    end
                    bcd_next   = '0;
                    cnt_next   = CW'(BCD_STEPS);
                    state_next = S_BCD;
                end
            end
            S_BCD: begin
                bcd_next = {bcd_adj[18:0], bin_reg[15]};
                bin_next = {bin_reg[14:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hand over once the output register is free
                if (!mvld_reg || m_tready) begin
                    mvld_next  = 1'b1;
                    mdat_next  = {2'b00,
                                  ASCII_ZERO + {2'b00, bcd_reg[3:0]},
                                  ASCII_ZERO + {2'b00, bcd_reg[7:4]},
                                  ASCII_ZERO + {2'b00, bcd_reg[11:8]},
                                  ASCII_ZERO + {2'b00, bcd_reg[15:12]},
                                  ASCII_ZERO + {2'b00, bcd_reg[19:16]},
                                  spd_reg, per_reg};
                    musr_next  = sat_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= '0;
            mvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            mvld_reg  <= mvld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        per_reg  <= per_next;
        spd_reg  <= spd_next;
        sat_reg  <= sat_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        mdat_reg <= mdat_next;
        musr_reg <= musr_next;
    end

    assign m_tvalid = mvld_reg;
    assign m_tdata  = mdat_reg;
    assign m_tuser  = musr_reg;

    // Checks
    `EPSA_ASSERT(a_accept_starts_div, accept |=> state_reg == S_DIV_US, "accepted word did not start the divider")
    `EPSA_ASSERT(a_rem_below_divisor, (state_reg == S_DIV_US || state_reg == S_DIV_SPD) |-> rem_reg < dsr_reg, "divider remainder not below divisor")
    `EPSA_ASSERT(a_bcd_digits, state_reg == S_OUT |-> (bcd_reg[3:0] <= 4'd9 && bcd_reg[7:4] <= 4'd9 && bcd_reg[11:8] <= 4'd9 && bcd_reg[15:12] <= 4'd9 && bcd_reg[19:16] <= 4'd6), "BCD digit out of range")
    `EPSA_ASSERT(a_sat_clamps, (m_tvalid && m_tuser) |-> m_tdata[31:16] == SPEED_MAX, "saturated result without clamped speed")
    `EPSA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == S_IDLE && !mvld_reg), "reset left sequencer busy")

endmodule
